### sv/bir_pkg.sv
// Shared constants for the bilinear image rescaler.
`timescale 1ns / 1ps
`default_nettype none

package bir_pkg;

  // Source store geometry and sample format.
  localparam int MAX_SOURCE_COLUMNS = 128;
  localparam int MAX_SOURCE_ROWS    = 128;
  localparam int PIXEL_BITS         = 24;
  localparam int FRACTION_BITS      = 16;

  // Address bits of one row or one column, and of one of the four parity banks.
  localparam int COL_AW    = $clog2(MAX_SOURCE_COLUMNS);
  localparam int ROW_AW    = $clog2(MAX_SOURCE_ROWS);
  localparam int BANK_AW   = ROW_AW + COL_AW - 2;
  localparam int BANK_DEPTH = 2 ** BANK_AW;
  localparam int NUM_BANKS = 4;

  // Field and register widths.
  localparam int IDX_W   = 8;
  localparam int SIZE_W  = 8;
  localparam int STEP_W  = 24;
  localparam int OFFS_W  = 23;
  localparam int COORD_W = 32;
  localparam int INT_W   = COORD_W - FRACTION_BITS;

  // Datapath widths of the blend.
  localparam int WGT_W    = FRACTION_BITS + 1;
  localparam int PROD_W   = PIXEL_BITS + WGT_W;
  localparam int HSUM_W   = PIXEL_BITS + FRACTION_BITS;
  localparam int LOPROD_W = FRACTION_BITS + WGT_W;
  localparam int LOSUM_W  = 2 * FRACTION_BITS;

  // Configuration port.
  localparam int APB_AW = 5;
  localparam int APB_DW = 32;
  localparam int REG_IDX_W = APB_AW - 2;

  localparam logic [REG_IDX_W-1:0] REG_SOURCE_COLUMNS = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SOURCE_ROWS    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_STEP_RATIO     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_COLUMN_OFFSET  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ROW_OFFSET     = 3'd4;

  // Input item modes.
  localparam logic MODE_WRITE   = 1'b0;
  localparam logic MODE_REQUEST = 1'b1;

endpackage

`default_nettype wire

### sv/bir_ram.sv
// Generic simple dual-port RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none

module bir_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write and one registered read each cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### sv/bilinear_image_rescaler_core.sv
// Top level of the bilinear image rescaler: register file, sequencer and blend datapath.
`timescale 1ns / 1ps
`default_nettype none

// The block holds a source image of up to 128 x 128 samples in four RAM banks split by
// row and column parity, so the four neighbours of any position come out of a single
// read of the banks. A write beat (mode 0) stores one sample when it is taken; write
// beats can follow each other every cycle while the block is idle. A request beat
// (mode 1) runs through a six-step sequencer (coordinate multiply, bank read, two
// product and sum steps for the horizontal and vertical blends) and its result lands in
// an output register at the end of the last step; the next beat is taken in the cycle
// after that, even while the result still waits to be taken. No new beat is taken while
// a request is in the sequencer, and the last step holds while an earlier result waits.
// Neighbours beyond the configured source size read as zero and raise outside_source.
// No clearing pass is run after reset: a sample must be written before it is read.

module bilinear_image_rescaler_core
  import bir_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // Input channel
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     in_mode,
  input  wire logic [IDX_W-1:0]         in_row_index,
  input  wire logic [IDX_W-1:0]         in_column_index,
  input  wire logic [PIXEL_BITS-1:0]    in_pixel_value,
  // Result channel
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic      [PIXEL_BITS-1:0]    out_sample_value,
  output logic                          out_outside_source,
  // Configuration port
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [APB_AW-1:0]        paddr,
  input  wire logic [APB_DW-1:0]        pwdata,
  output logic      [APB_DW-1:0]        prdata,
  output logic                          pready
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_COORD = 3'd1;
  localparam logic [2:0] ST_FETCH = 3'd2;
  localparam logic [2:0] ST_HPROD = 3'd3;
  localparam logic [2:0] ST_HSUM  = 3'd4;
  localparam logic [2:0] ST_VPROD = 3'd5;
  localparam logic [2:0] ST_VSUM  = 3'd6;

  localparam logic [WGT_W-1:0] FRAC_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

  // Configuration registers
  logic [SIZE_W-1:0] src_cols_r;
  logic [SIZE_W-1:0] src_rows_r;
  logic [STEP_W-1:0] step_r;
  logic [OFFS_W-1:0] col_off_r;
  logic [OFFS_W-1:0] row_off_r;
  logic              cfg_wr;
  logic [REG_IDX_W-1:0] reg_idx;

  // Sequencer
  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       in_acc;
  logic       out_load;

  // Request datapath
  logic [IDX_W-1:0]   req_row_r;
  logic [IDX_W-1:0]   req_col_r;
  logic [COORD_W-1:0] x_r;
  logic [COORD_W-1:0] y_r;
  logic [INT_W-1:0]   ci;
  logic [INT_W-1:0]   ri;
  logic [INT_W:0]     ci1;
  logic [INT_W:0]     ri1;
  logic [SIZE_W-1:0]  nc;
  logic [SIZE_W-1:0]  nr;
  logic [1:0]         row_out;
  logic [1:0]         col_out;
  logic [1:0]         row_out_r;
  logic [1:0]         col_out_r;
  logic               outside_r;
  logic               rpar_r;
  logic               cpar_r;
  logic [WGT_W-1:0]   fx_r;
  logic [WGT_W-1:0]   fy_r;
  logic [WGT_W-1:0]   wx0;
  logic [WGT_W-1:0]   wy0;
  logic [PIXEL_BITS-1:0] nb [2][2];
  logic [PROD_W-1:0]  hp_r [2][2];
  logic [HSUM_W-1:0]  r_r [2];
  logic [PROD_W-1:0]  vp_r [2];
  logic [LOPROD_W-1:0] lp_r [2];
  logic [HSUM_W-1:0]  hi_sum;
  logic [LOSUM_W-1:0] lo_sum;
  logic [HSUM_W-1:0]  total;

  // Banks
  logic [1:0]            wr_bank;
  logic [BANK_AW-1:0]    wr_addr;
  logic                  wr_ok;
  logic [NUM_BANKS-1:0]  ram_we;
  logic [BANK_AW-1:0]    bank_raddr [NUM_BANKS];
  logic [PIXEL_BITS-1:0] bank_rdata [NUM_BANKS];

  // Output register
  logic                  out_valid_r;
  logic [PIXEL_BITS-1:0] out_sample_r;
  logic                  out_outside_r;

  // ---------------------------------------------------------------------------------
  // Configuration port: writes land in the access cycle, reads return the register.
  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_cols_r <= SIZE_W'(MAX_SOURCE_COLUMNS);
      src_rows_r <= SIZE_W'(MAX_SOURCE_ROWS);
      step_r     <= STEP_W'(1) << FRACTION_BITS;
      col_off_r  <= '0;
      row_off_r  <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_SOURCE_COLUMNS: src_cols_r <= pwdata[SIZE_W-1:0];
        REG_SOURCE_ROWS:    src_rows_r <= pwdata[SIZE_W-1:0];
        REG_STEP_RATIO:     step_r     <= pwdata[STEP_W-1:0];
        REG_COLUMN_OFFSET:  col_off_r  <= pwdata[OFFS_W-1:0];
        REG_ROW_OFFSET:     row_off_r  <= pwdata[OFFS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SOURCE_COLUMNS: prdata = APB_DW'(src_cols_r);
      REG_SOURCE_ROWS:    prdata = APB_DW'(src_rows_r);
      REG_STEP_RATIO:     prdata = APB_DW'(step_r);
      REG_COLUMN_OFFSET:  prdata = APB_DW'(col_off_r);
      REG_ROW_OFFSET:     prdata = APB_DW'(row_off_r);
      default:            prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------------
  // Sequencer: idle takes beats, a request walks through the blend steps.
  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid & in_ready;
  assign out_load = (state_r == ST_VSUM) & (~out_valid_r | out_ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_acc && in_mode == MODE_REQUEST) begin
        state_nxt = ST_COORD;
      end
      ST_COORD: state_nxt = ST_FETCH;
      ST_FETCH: state_nxt = ST_HPROD;
      ST_HPROD: state_nxt = ST_HSUM;
      ST_HSUM:  state_nxt = ST_VPROD;
      ST_VPROD: state_nxt = ST_VSUM;
      ST_VSUM:  if (out_load) begin
        state_nxt = ST_IDLE;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------------------------
  // Source writes go to the bank picked by row and column parity.
  assign wr_bank = {in_row_index[0], in_column_index[0]};
  assign wr_addr = {in_row_index[ROW_AW-1:1], in_column_index[COL_AW-1:1]};
  assign wr_ok   = (in_row_index < IDX_W'(MAX_SOURCE_ROWS)) &&
                   (in_column_index < IDX_W'(MAX_SOURCE_COLUMNS));

  // Read addresses: each bank serves whichever of the two rows and columns has its parity.
  assign ci  = x_r[COORD_W-1:FRACTION_BITS];
  assign ri  = y_r[COORD_W-1:FRACTION_BITS];
  assign ci1 = {1'b0, ci} + (INT_W+1)'(1);
  assign ri1 = {1'b0, ri} + (INT_W+1)'(1);

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    localparam logic [1:0] BK = 2'(b);
    logic [ROW_AW-1:0] rsel;
    logic [COL_AW-1:0] csel;

    assign rsel = (ri[0] == BK[1]) ? ri[ROW_AW-1:0] : ri1[ROW_AW-1:0];
    assign csel = (ci[0] == BK[0]) ? ci[COL_AW-1:0] : ci1[COL_AW-1:0];
    assign bank_raddr[b] = {rsel[ROW_AW-1:1], csel[COL_AW-1:1]};
    assign ram_we[b] = in_acc & (in_mode == MODE_WRITE) & wr_ok & (wr_bank == BK);

    bir_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (BANK_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (ram_we[b]),
      .waddr (wr_addr),
      .wdata (in_pixel_value),
      .raddr (bank_raddr[b]),
      .rdata (bank_rdata[b])
    );
  end

  // ---------------------------------------------------------------------------------
  // Effective source size, saturated at the store size.
  assign nc = (src_cols_r > SIZE_W'(MAX_SOURCE_COLUMNS)) ? SIZE_W'(MAX_SOURCE_COLUMNS)
                                                          : src_cols_r;
  assign nr = (src_rows_r > SIZE_W'(MAX_SOURCE_ROWS)) ? SIZE_W'(MAX_SOURCE_ROWS)
                                                       : src_rows_r;

  assign col_out[0] = ci  >= INT_W'(nc);
  assign col_out[1] = ci1 >= (INT_W+1)'(nc);
  assign row_out[0] = ri  >= INT_W'(nr);
  assign row_out[1] = ri1 >= (INT_W+1)'(nr);

  // Weights of the near neighbours.
  assign wx0 = FRAC_ONE - fx_r;
  assign wy0 = FRAC_ONE - fy_r;

  // Neighbours out of the banks; anything outside the source reads as zero.
  always_comb begin
    for (int dr = 0; dr < 2; dr++) begin
      for (int dc = 0; dc < 2; dc++) begin
        nb[dr][dc] = (row_out_r[dr] | col_out_r[dc]) ? '0 :
                     bank_rdata[{rpar_r ^ 1'(dr), cpar_r ^ 1'(dc)}];
      end
    end
  end

  // Final vertical sum: high part plus the carry out of the low part.
  assign hi_sum = HSUM_W'(vp_r[0] + vp_r[1]);
  assign lo_sum = LOSUM_W'(lp_r[0] + lp_r[1]);
  assign total  = hi_sum + HSUM_W'(lo_sum >> FRACTION_BITS);

  // Datapath registers, each loaded in its own step.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_row_r <= in_row_index;
      req_col_r <= in_column_index;
    end
    if (state_r == ST_COORD) begin
      x_r <= COORD_W'(col_off_r) + COORD_W'(req_col_r) * COORD_W'(step_r);
      y_r <= COORD_W'(row_off_r) + COORD_W'(req_row_r) * COORD_W'(step_r);
    end
    if (state_r == ST_FETCH) begin
      row_out_r <= row_out;
      col_out_r <= col_out;
      outside_r <= |{row_out, col_out};
      rpar_r    <= ri[0];
      cpar_r    <= ci[0];
      fx_r      <= WGT_W'(x_r[FRACTION_BITS-1:0]);
      fy_r      <= WGT_W'(y_r[FRACTION_BITS-1:0]);
    end
    if (state_r == ST_HPROD) begin
      for (int dr = 0; dr < 2; dr++) begin
        hp_r[dr][0] <= PROD_W'(nb[dr][0]) * PROD_W'(wx0);
        hp_r[dr][1] <= PROD_W'(nb[dr][1]) * PROD_W'(fx_r);
      end
    end
    if (state_r == ST_HSUM) begin
      for (int dr = 0; dr < 2; dr++) begin
        r_r[dr] <= HSUM_W'(hp_r[dr][0] + hp_r[dr][1]);
      end
    end
    if (state_r == ST_VPROD) begin
      vp_r[0] <= PROD_W'(r_r[0][HSUM_W-1:FRACTION_BITS]) * PROD_W'(wy0);
      vp_r[1] <= PROD_W'(r_r[1][HSUM_W-1:FRACTION_BITS]) * PROD_W'(fy_r);
      lp_r[0] <= LOPROD_W'(r_r[0][FRACTION_BITS-1:0]) * LOPROD_W'(wy0);
      lp_r[1] <= LOPROD_W'(r_r[1][FRACTION_BITS-1:0]) * LOPROD_W'(fy_r);
    end
  end

  // ---------------------------------------------------------------------------------
  // Output register, which lets the next beat in while a result waits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample_r  <= total[HSUM_W-1:FRACTION_BITS];
      out_outside_r <= outside_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_sample_value   = out_sample_r;
  assign out_outside_source = out_outside_r;

  // ---------------------------------------------------------------------------------
  // Checks

  // A source write never lands while a request is reading the banks.
  a_write_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (|ram_we) |-> (state_r == ST_IDLE))
    else $error("source write outside the idle state");

  // An accepted request beat starts the coordinate step next cycle.
  a_request_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_mode == MODE_REQUEST) |=> (state_r == ST_COORD))
    else $error("request beat did not start the sequencer");

  // A finished blend is presented on the result channel and frees the sequencer.
  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid && state_r == ST_IDLE))
    else $error("finished result not presented");

endmodule

`default_nettype wire
